// ===== design/hcalu_pkg.sv =====
// ============================================================================
// hcalu_pkg: shared definitions of the handheld CPU ALU
// Operation codes, flag bit positions and the payload records that travel
// between the pipeline stages.
// ============================================================================
package hcalu_pkg;

    // Operation codes.
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADC   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_SBC   = 5'd3;
    localparam logic [4:0] OP_AND   = 5'd4;
    localparam logic [4:0] OP_OR    = 5'd5;
    localparam logic [4:0] OP_XOR   = 5'd6;
    localparam logic [4:0] OP_CP    = 5'd7;
    localparam logic [4:0] OP_INC   = 5'd8;
    localparam logic [4:0] OP_DEC   = 5'd9;
    localparam logic [4:0] OP_DAA   = 5'd10;
    localparam logic [4:0] OP_CPL   = 5'd11;
    localparam logic [4:0] OP_ADD16 = 5'd12;
    localparam logic [4:0] OP_INC16 = 5'd13;
    localparam logic [4:0] OP_DEC16 = 5'd14;
    localparam logic [4:0] OP_RL    = 5'd15;
    localparam logic [4:0] OP_RLC   = 5'd16;
    localparam logic [4:0] OP_RR    = 5'd17;
    localparam logic [4:0] OP_RRC   = 5'd18;
    localparam logic [4:0] OP_SLA   = 5'd19;
    localparam logic [4:0] OP_SRA   = 5'd20;
    localparam logic [4:0] OP_SRL   = 5'd21;
    localparam logic [4:0] OP_SWAP  = 5'd22;
    localparam logic [4:0] OP_BIT   = 5'd23;
    localparam logic [4:0] OP_SET   = 5'd24;
    localparam logic [4:0] OP_RES   = 5'd25;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust limits.
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'd9;

    // Accepted input item.
    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [3:0]  f;
    } t_item;

    // Decode stage output: operands plus the bit-level unit results.
    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [3:0]  f;
        logic        cy;     // carry or borrow in for adc and sbc
        logic [7:0]  lres;   // logic, complement, shift, rotate, swap, set and reset result
        logic        lcy;    // carry out of the shifter
        logic        bitz;   // tested bit is clear
    } t_dec;

    // Execute stage output: final value, flags with Z still pending.
    typedef struct packed {
        logic [15:0] res;
        logic [7:0]  zval;   // byte that Z is taken from
        logic        zsel;   // Z comes from zval instead of flg
        logic [3:0]  flg;
    } t_exe;

    // Result item.
    typedef struct packed {
        logic [15:0] res;
        logic [3:0]  flg;
    } t_res;

endpackage

// ===== design/hcalu_decode.sv =====
// ============================================================================
// hcalu_decode: first pipeline stage
// Registers the incoming item together with the results of the bit-level
// unit (logic operations, shifts, rotates, swap, bit test, set and reset).
// ============================================================================
module hcalu_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  hcalu_pkg::t_item  i_dat,
    output logic              o_rdy,
    output logic              o_vld,
    output hcalu_pkg::t_dec   o_dat,
    input  logic              i_rdy
);

    logic             r_vld;
    hcalu_pkg::t_dec  r_dat;
    hcalu_pkg::t_dec  n_dat;
    logic [7:0]       a8;
    logic [7:0]       b8;
    logic [7:0]       mask;

    assign a8   = i_dat.a[7:0];
    assign b8   = i_dat.b[7:0];
    assign mask = 8'b1 << i_dat.b[2:0];

    // Bit-level unit.
    always_comb begin
        n_dat      = '0;
        n_dat.op   = i_dat.op;
        n_dat.a    = i_dat.a;
        n_dat.b    = i_dat.b;
        n_dat.f    = i_dat.f;
        n_dat.cy   = ((i_dat.op == hcalu_pkg::OP_ADC) || (i_dat.op == hcalu_pkg::OP_SBC))
                     & i_dat.f[hcalu_pkg::FLAG_C];
        n_dat.bitz = ((a8 & mask) == 8'd0);
        n_dat.lres = a8;
        n_dat.lcy  = 1'b0;
        unique case (i_dat.op)
            hcalu_pkg::OP_AND:  n_dat.lres = a8 & b8;
            hcalu_pkg::OP_OR:   n_dat.lres = a8 | b8;
            hcalu_pkg::OP_XOR:  n_dat.lres = a8 ^ b8;
            hcalu_pkg::OP_CPL:  n_dat.lres = ~a8;
            hcalu_pkg::OP_RL: begin
                n_dat.lres = {a8[6:0], i_dat.f[hcalu_pkg::FLAG_C]};
                n_dat.lcy  = a8[7];
            end
            hcalu_pkg::OP_RLC: begin
                n_dat.lres = {a8[6:0], a8[7]};
                n_dat.lcy  = a8[7];
            end
            hcalu_pkg::OP_RR: begin
                n_dat.lres = {i_dat.f[hcalu_pkg::FLAG_C], a8[7:1]};
                n_dat.lcy  = a8[0];
            end
            hcalu_pkg::OP_RRC: begin
                n_dat.lres = {a8[0], a8[7:1]};
                n_dat.lcy  = a8[0];
            end
            hcalu_pkg::OP_SLA: begin
                n_dat.lres = {a8[6:0], 1'b0};
                n_dat.lcy  = a8[7];
            end
            hcalu_pkg::OP_SRA: begin
                n_dat.lres = {a8[7], a8[7:1]};
                n_dat.lcy  = a8[0];
            end
            hcalu_pkg::OP_SRL: begin
                n_dat.lres = {1'b0, a8[7:1]};
                n_dat.lcy  = a8[0];
            end
            hcalu_pkg::OP_SWAP: n_dat.lres = {a8[3:0], a8[7:4]};
            hcalu_pkg::OP_SET:  n_dat.lres = a8 | mask;
            hcalu_pkg::OP_RES:  n_dat.lres = a8 & ~mask;
            default:            n_dat.lres = a8;
        endcase
    end

    // Stage register: loads whenever the slot is empty or drains.
    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end

    assign o_vld = r_vld;
    assign o_dat = r_dat;

endmodule

// ===== design/hcalu_exec.sv =====
// ============================================================================
// hcalu_exec: second pipeline stage
// Runs the 8-bit and 16-bit adders, the decimal adjust and the increment and
// decrement paths, and selects the result and the N, H and C flags.
// ============================================================================
module hcalu_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  hcalu_pkg::t_dec   i_dat,
    output logic              o_rdy,
    output logic              o_vld,
    output hcalu_pkg::t_exe   o_dat,
    input  logic              i_rdy
);

    logic             r_vld;
    hcalu_pkg::t_exe  r_dat;
    hcalu_pkg::t_exe  n_dat;
    logic [7:0]       a8;
    logic [7:0]       b8;
    logic [3:0]       f;
    logic [8:0]       sum9;
    logic [4:0]       hsum5;
    logic [8:0]       dif9;
    logic [4:0]       hdif5;
    logic [16:0]      sum17;
    logic [12:0]      hsum13;
    logic             dcy;
    logic             dh;
    logic [7:0]       corr;
    logic [7:0]       daa8;

    assign a8 = i_dat.a[7:0];
    assign b8 = i_dat.b[7:0];
    assign f  = i_dat.f;

    // Adders; bit 8 of the difference is the borrow out.
    assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, i_dat.cy};
    assign hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, i_dat.cy};
    assign dif9   = {1'b0, a8} - {1'b0, b8} - {8'd0, i_dat.cy};
    assign hdif5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, i_dat.cy};
    assign sum17  = {1'b0, i_dat.a} + {1'b0, i_dat.b};
    assign hsum13 = {1'b0, i_dat.a[11:0]} + {1'b0, i_dat.b[11:0]};

    // Decimal adjust: after an addition the incoming carries and the limits
    // decide, after a subtraction only the incoming carries do.
    assign dcy  = f[hcalu_pkg::FLAG_C]
                  | (!f[hcalu_pkg::FLAG_N] && (a8 > hcalu_pkg::DAA_HI_LIMIT));
    assign dh   = f[hcalu_pkg::FLAG_H]
                  | (!f[hcalu_pkg::FLAG_N] && (a8[3:0] > hcalu_pkg::DAA_LO_LIMIT));
    assign corr = {1'b0, dcy, dcy, 2'b00, dh, dh, 1'b0};
    assign daa8 = f[hcalu_pkg::FLAG_N] ? (a8 - corr) : (a8 + corr);

    // Result and flag selection; Z of 8-bit arithmetic, logic, shift and rotate results is finished next stage.
    always_comb begin
        n_dat.res  = i_dat.a;
        n_dat.zval = a8;
        n_dat.zsel = 1'b0;
        n_dat.flg  = f;
        unique case (i_dat.op)
            hcalu_pkg::OP_ADD, hcalu_pkg::OP_ADC: begin
                n_dat.res  = {8'd0, sum9[7:0]};
                n_dat.zval = sum9[7:0];
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b0, hsum5[4], sum9[8]};
            end
            hcalu_pkg::OP_SUB, hcalu_pkg::OP_SBC: begin
                n_dat.res  = {8'd0, dif9[7:0]};
                n_dat.zval = dif9[7:0];
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b1, hdif5[4], dif9[8]};
            end
            hcalu_pkg::OP_CP: begin
                n_dat.zval = dif9[7:0];
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b1, hdif5[4], dif9[8]};
            end
            hcalu_pkg::OP_AND: begin
                n_dat.res  = {8'd0, i_dat.lres};
                n_dat.zval = i_dat.lres;
                n_dat.zsel = 1'b1;
                n_dat.flg  = 4'b0010;
            end
            hcalu_pkg::OP_OR, hcalu_pkg::OP_XOR, hcalu_pkg::OP_SWAP: begin
                n_dat.res  = {8'd0, i_dat.lres};
                n_dat.zval = i_dat.lres;
                n_dat.zsel = 1'b1;
                n_dat.flg  = 4'b0000;
            end
            hcalu_pkg::OP_INC: begin
                n_dat.res  = {8'd0, a8 + 8'd1};
                n_dat.zval = a8 + 8'd1;
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b0, (a8[3:0] == 4'hF), f[hcalu_pkg::FLAG_C]};
            end
            hcalu_pkg::OP_DEC: begin
                n_dat.res  = {8'd0, a8 - 8'd1};
                n_dat.zval = a8 - 8'd1;
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b1, (a8[3:0] == 4'h0), f[hcalu_pkg::FLAG_C]};
            end
            hcalu_pkg::OP_DAA: begin
                n_dat.res  = {8'd0, daa8};
                n_dat.zval = daa8;
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, f[hcalu_pkg::FLAG_N], 1'b0, dcy};
            end
            hcalu_pkg::OP_CPL: begin
                n_dat.res  = {8'd0, i_dat.lres};
                n_dat.flg  = {f[hcalu_pkg::FLAG_Z], 1'b1, 1'b1, f[hcalu_pkg::FLAG_C]};
            end
            hcalu_pkg::OP_ADD16: begin
                n_dat.res  = sum17[15:0];
                n_dat.flg  = {f[hcalu_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            hcalu_pkg::OP_INC16: n_dat.res = i_dat.a + 16'd1;
            hcalu_pkg::OP_DEC16: n_dat.res = i_dat.a - 16'd1;
            hcalu_pkg::OP_RL, hcalu_pkg::OP_RLC, hcalu_pkg::OP_RR, hcalu_pkg::OP_RRC,
            hcalu_pkg::OP_SLA, hcalu_pkg::OP_SRA, hcalu_pkg::OP_SRL: begin
                n_dat.res  = {8'd0, i_dat.lres};
                n_dat.zval = i_dat.lres;
                n_dat.zsel = 1'b1;
                n_dat.flg  = {1'b0, 1'b0, 1'b0, i_dat.lcy};
            end
            hcalu_pkg::OP_BIT: begin
                n_dat.flg  = {i_dat.bitz, 1'b0, 1'b1, f[hcalu_pkg::FLAG_C]};
            end
            hcalu_pkg::OP_SET, hcalu_pkg::OP_RES: begin
                n_dat.res  = {8'd0, i_dat.lres};
            end
            default: begin
                n_dat.res  = i_dat.a;
            end
        endcase
    end

    // Stage register.
    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end

    assign o_vld = r_vld;
    assign o_dat = r_dat;

endmodule

// ===== design/hcalu_flags.sv =====
// ============================================================================
// hcalu_flags: third pipeline stage and output register
// Detects a zero result byte, merges it into the Z flag and holds the
// finished result until the downstream side takes it.
// ============================================================================
module hcalu_flags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  hcalu_pkg::t_exe   i_dat,
    output logic              o_rdy,
    output logic              o_vld,
    output hcalu_pkg::t_res   o_dat,
    input  logic              i_rdy
);

    logic             r_vld;
    hcalu_pkg::t_res  r_dat;
    hcalu_pkg::t_res  n_dat;

    // Zero detection on the selected byte.
    always_comb begin
        n_dat.res = i_dat.res;
        n_dat.flg = i_dat.flg;
        if (i_dat.zsel) begin
            n_dat.flg[hcalu_pkg::FLAG_Z] = (i_dat.zval == 8'd0);
        end
    end

    // Output register.
    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end

    assign o_vld = r_vld;
    assign o_dat = r_dat;

endmodule

// ===== design/handheld_cpu_alu_core.sv =====
// ============================================================================
// handheld_cpu_alu_core: pipelined 8/16-bit ALU of the handheld CPU
// Three register stages: bit-level unit, adders and selection, zero flag.
// ============================================================================
//
//  Channel  Direction  Contents
//  -------  ---------  ---------------------------------------------------
//  s_*      in         tuser: operation; tdata: operand_a, operand_b, flags_in
//  m_*      out        tdata: result, flags_out
//
//  One operation enters per cycle while s_tready is high; m_tvalid rises once
//  the item has passed the stage registers, and the result transfer completes
//  when the output side is not stalled.
//  The three stage registers are decode, execute and flags.
//  s_tready follows m_tready through the stage chain, so a stall fills the
//  empty stages first and then holds every item in place.
//  Synchronous active-low reset empties the pipeline; payloads are not reset.
//
module handheld_cpu_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operand_a [15:0], operand_b [31:16],
                                   // flags_in [35:32], zero [39:36]
    input  logic [4:0]  s_tuser,   // operation [4:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result [15:0], flags_out [19:16],
                                   // zero [23:20]
);

    hcalu_pkg::t_item  in_item;
    hcalu_pkg::t_dec   dec_dat;
    hcalu_pkg::t_exe   exe_dat;
    hcalu_pkg::t_res   res_dat;
    logic              dec_vld;
    logic              dec_rdy;
    logic              exe_vld;
    logic              exe_rdy;

    // Input unpacking.
    assign in_item.op = s_tuser;
    assign in_item.a  = s_tdata[15:0];
    assign in_item.b  = s_tdata[31:16];
    assign in_item.f  = s_tdata[35:32];

    hcalu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_tvalid),
        .i_dat   (in_item),
        .o_rdy   (s_tready),
        .o_vld   (dec_vld),
        .o_dat   (dec_dat),
        .i_rdy   (dec_rdy)
    );

    hcalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dec_vld),
        .i_dat   (dec_dat),
        .o_rdy   (dec_rdy),
        .o_vld   (exe_vld),
        .o_dat   (exe_dat),
        .i_rdy   (exe_rdy)
    );

    hcalu_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (exe_vld),
        .i_dat   (exe_dat),
        .o_rdy   (exe_rdy),
        .o_vld   (m_tvalid),
        .o_dat   (res_dat),
        .i_rdy   (m_tready)
    );

    // Output packing.
    assign m_tdata = {4'd0, res_dat.flg, res_dat.res};

endmodule
